// ===== rtl/core/sumh_pkg.sv =====
// Shared constants and types for the RC frame decoder.
package sumh_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned CH_IDX_W   = 3;
  localparam int unsigned CH_VAL_W   = 14;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned PROD_W     = 19;
  localparam int unsigned POS_W      = 5;

  localparam int unsigned FRAME_BYTES = 21;
  localparam int unsigned CHANNELS    = 8;

  localparam logic [POS_W-1:0]     LAST_POS      = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0]     SYNC_POS      = 5'd0;
  localparam logic [POS_W-1:0]     TAIL_POS      = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0]     FIRST_CH_POS  = 5'd3;
  localparam logic [BYTE_W-1:0]    SYNC_BYTE     = 8'hA8;
  localparam logic [BYTE_W-1:0]    TAIL_BYTE     = 8'h00;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [CH_VAL_W-1:0]  CH_OFFSET     = 14'd375;
  localparam logic [CH_IDX_W-1:0]  LAST_CH       = CH_IDX_W'(CHANNELS - 1);

  typedef struct packed {
    logic                load;
    logic [CH_IDX_W-1:0] index;
    logic                last;
  } ch_load_t;

endpackage

// ===== rtl/core/sumh_intf.sv =====
// Handshake interfaces for the byte, channel and configuration streams.
interface sumh_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [31:0] time_us;
  modport source (output valid, output rx_byte, output time_us, input ready);
  modport sink   (input valid, input rx_byte, input time_us, output ready);
endinterface

interface sumh_ch_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel_index;
  logic [13:0] channel_value;
  logic        last_channel;
  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

interface sumh_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sumh_chan_out.sv =====
// Channel scaling and output register.
module sumh_chan_out (
  input  logic               clk,
  input  logic               rst,
  input  sumh_pkg::ch_load_t ctrl,
  input  logic [7:0]         hi,
  input  logic [7:0]         lo,
  output logic               free,
  sumh_ch_if.source          ch
);
  import sumh_pkg::*;

  logic [RAW_W-1:0]    raw;
  logic [PROD_W-1:0]   prod;
  logic [CH_VAL_W-1:0] scaled;
  logic [CH_VAL_W-1:0] value;
  logic                out_valid;
  logic [CH_IDX_W-1:0] out_index;
  logic [CH_VAL_W-1:0] out_value;
  logic                out_last;

  // raw * 5 / 32, then remove the centre offset
  assign raw    = {hi, lo};
  assign prod   = {3'b000, raw} + {1'b0, raw, 2'b00};
  assign scaled = prod[PROD_W-1:5];
  assign value  = (scaled < CH_OFFSET) ? '0 : scaled - CH_OFFSET;

  assign free = !out_valid || ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load && free) begin
      out_valid <= 1'b1;
    end else if (ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && free) begin
      out_index <= ctrl.index;
      out_value <= value;
      out_last  <= ctrl.last;
    end
  end

  assign ch.valid         = out_valid;
  assign ch.channel_index = out_index;
  assign ch.channel_value = out_value;
  assign ch.last_channel  = out_last;

endmodule

// ===== rtl/core/sumh_rc_frame_decoder_top.sv =====
// Top level of the serial RC frame decoder.
//
//  port  dir   carries
//  rx    sink  rx_byte, time_us (one received byte)
//  ch    src   channel_index, channel_value, last_channel
//  cfg   sink  data (gap_timeout_us)
//
// rx takes a byte whenever the decoder is idle; rx is held off while a frame is being emitted.
// A passing frame emits eight channels, each by two store reads through the
// single read port, then the scale step.
// rst is synchronous; the frame store has no reset and is never read unwritten.
// A stalled ch holds the emit sequence at the scale step.
module sumh_rc_frame_decoder_top (
  input  logic       clk,
  input  logic       rst,
  sumh_rx_if.sink    rx,
  sumh_ch_if.source  ch,
  sumh_cfg_if.sink   cfg
);
  import sumh_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HI   = 2'd1;
  localparam logic [1:0] S_LO   = 2'd2;
  localparam logic [1:0] S_CALC = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     pos_eff;
  logic [TIME_W-1:0]    prev_time;
  logic [TIME_W-1:0]    gap;
  logic [TIMEOUT_W-1:0] timeout;
  logic                 sync_ok;
  logic                 tail_ok;
  logic [CH_IDX_W-1:0]  chan;
  logic                 rx_fire;
  logic                 frame_pass;

  logic [BYTE_W-1:0]    store [FRAME_BYTES];
  logic                 rd_en;
  logic [POS_W-1:0]     rd_addr;
  logic [BYTE_W-1:0]    rd_data;
  logic [BYTE_W-1:0]    hi_q;

  ch_load_t             ld;
  logic                 out_free;

  assign cfg.ready = 1'b1;
  assign rx.ready  = (state == S_IDLE);
  assign rx_fire   = rx.valid && rx.ready;

  assign gap        = rx.time_us - prev_time;
  assign pos_eff    = (gap > {16'd0, timeout}) ? '0 : pos;
  assign frame_pass = sync_ok && tail_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      timeout <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      prev_time <= '0;
      sync_ok   <= 1'b0;
      tail_ok   <= 1'b0;
    end else if (rx_fire) begin
      prev_time <= rx.time_us;
      if (pos_eff != LAST_POS) begin
        pos <= pos_eff + 5'd1;
      end else begin
        pos <= pos_eff;
      end
      if (pos_eff == SYNC_POS) begin
        sync_ok <= (rx.rx_byte == SYNC_BYTE);
      end
      if (pos_eff == TAIL_POS) begin
        tail_ok <= (rx.rx_byte == TAIL_BYTE);
      end
    end
  end

  // frame store: written on byte arrival, read during emission
  always_ff @(posedge clk) begin
    if (rx_fire) begin
      store[pos_eff] <= rx.rx_byte;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  assign rd_en   = (state == S_HI) || (state == S_LO);
  assign rd_addr = {1'b0, chan, 1'b0} + FIRST_CH_POS + ((state == S_LO) ? 5'd1 : 5'd0);

  always_ff @(posedge clk) begin
    if (state == S_LO) begin
      hi_q <= rd_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (rx_fire && pos_eff == LAST_POS && frame_pass) begin
          state_next = S_HI;
        end
      end
      S_HI:   state_next = S_LO;
      S_LO:   state_next = S_CALC;
      S_CALC: begin
        if (out_free) begin
          state_next = (chan == LAST_CH) ? S_IDLE : S_HI;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan  <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        chan <= '0;
      end else if (state == S_CALC && out_free) begin
        chan <= chan + 3'd1;
      end
    end
  end

  assign ld.load  = (state == S_CALC);
  assign ld.index = chan;
  assign ld.last  = (chan == LAST_CH);

  sumh_chan_out u_chan_out (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ld),
    .hi   (hi_q),
    .lo   (rd_data),
    .free (out_free),
    .ch   (ch)
  );

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LAST_POS)
    else $error("write position beyond last slot");

  a_new_result_from_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(ch.valid) |-> $past(state == S_CALC))
    else $error("channel result without scale step");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    ch.valid |-> (ch.last_channel == (ch.channel_index == LAST_CH)))
    else $error("last_channel mismatch");

  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && pos_eff == LAST_POS && frame_pass) |=> (state == S_HI))
    else $error("valid frame not emitted");

endmodule

// ===== verif/sumh_rc_frame_decoder_top_tb.sv =====
// Self-checking testbench for the serial RC frame decoder: frames, gap timeouts and stalls.
`timescale 1ns / 100ps

module sumh_rc_frame_decoder_top_tb;
  import sumh_pkg::*;

  localparam int unsigned IDLE_PCT    = 15;
  localparam int unsigned SCALE_MUL   = 5;
  localparam int unsigned SCALE_SHIFT = 5;
  localparam int unsigned SETTLE_CYC  = 40;

  // known-good frame: clamp, full scale, exact zero and one-above-zero channels
  localparam logic [FRAME_BYTES*BYTE_W-1:0] DEMO_FRAME = {
    SYNC_BYTE, 8'h5A, 8'hC3, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h09, 8'h60, 8'h09, 8'h67,
    8'h80, 8'h00, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'h12, 8'h34, TAIL_BYTE, 8'h7F
  };

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [TIME_W-1:0] stamp;
  } rx_byte_t;

  typedef struct packed {
    logic [CH_IDX_W-1:0] index;
    logic [CH_VAL_W-1:0] value;
    logic                last;
  } channel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 rx_valid = 1'b0;
  logic [BYTE_W-1:0]    rx_data = '0;
  logic [TIME_W-1:0]    rx_stamp = '0;
  logic                 ch_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_data = '0;

  sumh_rx_if  rx_if ();
  sumh_ch_if  ch_if ();
  sumh_cfg_if cfg_if ();

  assign rx_if.valid   = rx_valid;
  assign rx_if.rx_byte = rx_data;
  assign rx_if.time_us = rx_stamp;
  assign ch_if.ready   = ch_ready;
  assign cfg_if.valid  = cfg_valid;
  assign cfg_if.data   = cfg_data;

  sumh_rc_frame_decoder_top i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .ch  (ch_if),
    .cfg (cfg_if)
  );

  always #5 clk = ~clk;

  // stimulus side
  rx_byte_t          byte_queue[$];
  int                rx_sent = 0;
  int                rx_accepted = 0;
  bit                calm = 1'b0;
  logic [TIME_W-1:0] stamp_now = '0;
  int unsigned       cur_timeout = TIMEOUT_RESET;
  int                bytes_queued = 0;
  int                settings_written = 0;

  // decoder image
  logic [BYTE_W-1:0]    frame_img [FRAME_BYTES];
  logic [POS_W-1:0]     wr_pos = '0;
  logic [TIME_W-1:0]    prev_stamp = '0;
  logic [TIMEOUT_W-1:0] gap_limit = TIMEOUT_RESET;
  channel_t             expected_channels[$];

  int errors = 0;
  int channels_checked = 0;
  int frames_decoded = 0;

  function automatic logic [CH_VAL_W-1:0] scale_channel(input logic [BYTE_W-1:0] hi,
                                                        input logic [BYTE_W-1:0] lo);
    logic [PROD_W-1:0]   product;
    logic [CH_VAL_W-1:0] scaled;
    product = PROD_W'({hi, lo}) * PROD_W'(SCALE_MUL);
    scaled  = CH_VAL_W'(product >> SCALE_SHIFT);
    if (scaled < CH_OFFSET) return '0;
    return scaled - CH_OFFSET;
  endfunction

  task automatic predict_byte(input logic [BYTE_W-1:0] data, input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] gap;
    channel_t          res;
    gap = stamp - prev_stamp;
    prev_stamp = stamp;
    if (gap > TIME_W'(gap_limit)) wr_pos = '0;
    if (wr_pos > LAST_POS) wr_pos = LAST_POS;
    frame_img[wr_pos] = data;
    if (wr_pos != LAST_POS) begin
      wr_pos = wr_pos + 1'b1;
    end else if (frame_img[SYNC_POS] == SYNC_BYTE && frame_img[TAIL_POS] == TAIL_BYTE) begin
      for (int c = 0; c < CHANNELS; c++) begin
        res.index = CH_IDX_W'(c);
        res.value = scale_channel(frame_img[FIRST_CH_POS + 2*c],
                                  frame_img[FIRST_CH_POS + 2*c + 1]);
        res.last  = (res.index == LAST_CH);
        expected_channels.push_back(res);
      end
      frames_decoded++;
    end
  endtask

  task automatic check_channel(input channel_t got);
    channel_t want;
    channels_checked++;
    if (expected_channels.size() == 0) begin
      $display("%0t: unexpected channel: idx %0d value %0d last %0d",
               $time, got.index, got.value, got.last);
      errors++;
    end else begin
      want = expected_channels.pop_front();
      if (got.index !== want.index || got.value !== want.value || got.last !== want.last) begin
        $display({"%0t: channel mismatch: expected idx %0d value %0d last %0d, ",
                  "actual idx %0d value %0d last %0d"},
                 $time, want.index, want.value, want.last, got.index, got.value, got.last);
        errors++;
      end
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (ch_if.valid && ch_if.ready)
        check_channel({ch_if.channel_index, ch_if.channel_value, ch_if.last_channel});
      if (cfg_if.valid && cfg_if.ready) gap_limit = cfg_if.data;
      if (rx_if.valid && rx_if.ready) begin
        predict_byte(rx_if.rx_byte, rx_if.time_us);
        rx_accepted++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    ch_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
    if (rx_accepted == rx_sent) begin
      if (!rst && byte_queue.size() > rx_sent && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
        rx_valid <= 1'b1;
        rx_data  <= byte_queue[rx_sent].data;
        rx_stamp <= byte_queue[rx_sent].stamp;
        rx_sent  <= rx_sent + 1;
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic [TIME_W-1:0] gap);
    stamp_now = stamp_now + gap;
    byte_queue.push_back({data, stamp_now});
    bytes_queued++;
  endtask

  function automatic logic [TIME_W-1:0] held_gap();
    if ($urandom_range(7, 0) == 0) return TIME_W'(cur_timeout);
    return TIME_W'($urandom_range(cur_timeout, 0));
  endfunction

  function automatic logic [TIME_W-1:0] restart_gap();
    logic [TIME_W-1:0] gap;
    if ($urandom_range(1, 0)) begin
      gap = TIME_W'(cur_timeout + 1 + $urandom_range(300, 0));
    end else begin
      gap = $urandom();
      if (gap <= cur_timeout) gap = TIME_W'(cur_timeout + 1);
    end
    return gap;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return BYTE_W'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic queue_frame(input bit sync_ok, input bit tail_ok, input int extras);
    logic [BYTE_W-1:0] data;
    data = rand_byte();
    if (sync_ok) data = SYNC_BYTE;
    else if (data == SYNC_BYTE) data = ~data;
    queue_byte(data, restart_gap());
    for (int pos = 1; pos < FRAME_BYTES; pos++) begin
      data = rand_byte();
      if (pos == TAIL_POS) data = tail_ok ? TAIL_BYTE : BYTE_W'($urandom_range(255, 1));
      queue_byte(data, held_gap());
    end
    repeat (extras) queue_byte(rand_byte(), held_gap());
  endtask

  // mostly whole frames, some with bad sync or tail, the rest stray bytes
  task automatic queue_mix(input int count);
    int target;
    int pick;
    target = bytes_queued + count;
    while (bytes_queued < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 60) queue_frame(1'b1, 1'b1, $urandom_range(3, 0));
      else if (pick < 70) queue_frame(1'b0, 1'b1, 0);
      else if (pick < 80) queue_frame(1'b1, 1'b0, $urandom_range(1, 0));
      else repeat ($urandom_range(6, 1))
        queue_byte(rand_byte(), $urandom_range(1, 0) ? held_gap() : restart_gap());
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() > rx_sent || rx_accepted != rx_sent || expected_channels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] limit);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_timeout = limit;
    settings_written++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first byte lands just below the wrap; the frame crosses it
    queue_byte(DEMO_FRAME[(FRAME_BYTES-1)*BYTE_W +: BYTE_W], 32'hFFFF_F000);
    for (int i = 1; i < FRAME_BYTES; i++)
      queue_byte(DEMO_FRAME[(FRAME_BYTES-1-i)*BYTE_W +: BYTE_W],
                 (i == 1) ? TIME_W'(cur_timeout) : TIME_W'(400));
    queue_byte(8'h3C, '0);
    queue_byte(SYNC_BYTE, TIME_W'(cur_timeout + 1));
    queue_byte(8'hFF, TIME_W'(cur_timeout));
    wait_drained();

    write_timeout('0);
    queue_mix(16);
    wait_drained();

    calm = 1'b1;
    write_timeout('1);
    queue_mix(16);
    wait_drained();
    calm = 1'b0;

    write_timeout(TIMEOUT_W'($urandom_range(65534, 1)));
    queue_mix(30);
    wait_drained();

    write_timeout(TIMEOUT_W'($urandom_range(2000, 100)));
    queue_mix(12);
    wait_drained();

    $display("Bytes accepted: %0d across %0d timeout settings plus reset value",
             rx_accepted, settings_written);
    $display("Frames decoded: %0d, channel transactions checked: %0d, errors: %0d",
             frames_decoded, channels_checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d channels still expected", expected_channels.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
